// ===== rtl/pds_pkg.sv =====
// Shared widths, reset values, register indexes and types for the PLL divider search.
package pds_pkg;

	// Fixed field widths
	localparam int REF_W      = 16;
	localparam int WIN_W      = 24;
	localparam int PFD_W      = 16;
	localparam int TGT_W      = 24;
	localparam int PDIV_W     = 6;
	localparam int FDIV_W     = 10;
	localparam int SHIFT_W    = 3;
	localparam int FREQ_W     = 27;
	localparam int DEN_W      = REF_W + 1;

	// Config port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Parameter defaults
	localparam int DEF_PRE_DIV_MAX      = 63;
	localparam int DEF_FB_DIV_MAX       = 1023;
	localparam int DEF_POST_SHIFT_COUNT = 7;

	localparam int FB_DIV_MIN = 64;

	// Register reset values
	localparam logic [REF_W-1:0] RST_REF     = 16'd24000;
	localparam logic [WIN_W-1:0] RST_VCO_MIN = 24'd2600000;
	localparam logic [WIN_W-1:0] RST_VCO_MAX = 24'd6600000;
	localparam logic [PFD_W-1:0] RST_PFD_MIN = 16'd6000;
	localparam logic [PFD_W-1:0] RST_PFD_MAX = 16'd30000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REF     = 3'd0,
		CFG_VCO_MIN = 3'd1,
		CFG_VCO_MAX = 3'd2,
		CFG_PFD_MIN = 3'd3,
		CFG_PFD_MAX = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [REF_W-1:0] ref_khz;
		logic [WIN_W-1:0] vco_min;
		logic [WIN_W-1:0] vco_max;
		logic [PFD_W-1:0] pfd_min;
		logic [PFD_W-1:0] pfd_max;
	} cfg_t;

endpackage

// ===== rtl/pds_div.sv =====
// Shared restoring divider, one quotient bit per cycle, quotient width set by steps.
module pds_div #(
	parameter int NUM_W  = 48,
	parameter int QUO_W  = 27,
	parameter int STEP_W = 5
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [NUM_W-1:0]         num,
	input  logic [pds_pkg::DEN_W-1:0] den,
	input  logic [STEP_W-1:0]        steps,
	output logic                     done,
	output logic [QUO_W-1:0]         quot
);

	logic [NUM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  dsh_q;
	logic [QUO_W-1:0]  quot_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              ge;

	// caller guarantees num < den << steps
	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			rem_q  <= num;
			dsh_q  <= NUM_W'(den) << (steps - 1'b1);
			quot_q <= '0;
			cnt_q  <= steps;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[QUO_W-2:0], ge};
			dsh_q  <= dsh_q >> 1;
			cnt_q  <= cnt_q - 1'b1;
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== rtl/pds_front.sv =====
// Front end: takes targets, flags the shifts whose VCO lands in the window, queues them.
module pds_front #(
	parameter int POST_SHIFT_COUNT = pds_pkg::DEF_POST_SHIFT_COUNT,
	parameter int VCO_W            = pds_pkg::TGT_W + POST_SHIFT_COUNT - 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pds_pkg::cfg_t               cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [pds_pkg::TGT_W-1:0]   target_khz,
	output logic                        q_valid,
	input  logic                        q_pop,
	output logic [pds_pkg::TGT_W-1:0]   q_target,
	output logic [POST_SHIFT_COUNT-1:0] q_mask
);

	localparam int QDEPTH = 2;

	logic [pds_pkg::TGT_W-1:0]   tgt_mem  [QDEPTH];
	logic [POST_SHIFT_COUNT-1:0] mask_mem [QDEPTH];
	logic                        wr_ptr_q;
	logic                        rd_ptr_q;
	logic [1:0]                  cnt_q;
	logic [POST_SHIFT_COUNT-1:0] mask;
	logic                        push;
	logic                        pop;

	// one window compare per post shift
	always_comb begin
		logic [VCO_W-1:0] vco;
		vco = '0;
		for (int s = 0; s < POST_SHIFT_COUNT; s++) begin
			vco     = VCO_W'(target_khz) << s;
			mask[s] = (cfg.ref_khz != '0) && (vco >= VCO_W'(cfg.vco_min))
				&& (vco <= VCO_W'(cfg.vco_max));
		end
	end

	assign in_ready = cnt_q != 2'(QDEPTH);
	assign q_valid  = cnt_q != 2'd0;
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;
	assign q_target = tgt_mem[rd_ptr_q];
	assign q_mask   = mask_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			tgt_mem[wr_ptr_q]  <= target_khz;
			mask_mem[wr_ptr_q] <= mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/pds_back.sv =====
// Back end: walks (S, P) pairs for one queued target and keeps the best divider set.
module pds_back #(
	parameter int PRE_DIV_MAX      = pds_pkg::DEF_PRE_DIV_MAX,
	parameter int FB_DIV_MAX       = pds_pkg::DEF_FB_DIV_MAX,
	parameter int POST_SHIFT_COUNT = pds_pkg::DEF_POST_SHIFT_COUNT,
	parameter int VCO_W            = pds_pkg::TGT_W + POST_SHIFT_COUNT - 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pds_pkg::cfg_t                 cfg,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  logic [pds_pkg::TGT_W-1:0]     q_target,
	input  logic [POST_SHIFT_COUNT-1:0]   q_mask,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic [pds_pkg::PDIV_W-1:0]    pre_div,
	output logic [pds_pkg::FDIV_W-1:0]    fb_div,
	output logic [pds_pkg::SHIFT_W-1:0]   post_shift,
	output logic [pds_pkg::FREQ_W-1:0]    achieved_khz,
	output logic [pds_pkg::FREQ_W-1:0]    error_khz
);

	localparam int PW     = $clog2(PRE_DIV_MAX + 1);
	localparam int FBW    = $clog2(FB_DIV_MAX + 1);
	localparam int SCW    = $clog2(POST_SHIFT_COUNT + 1);
	localparam int GW     = FBW + pds_pkg::DEN_W;
	localparam int NW1    = VCO_W + PW + 1;
	localparam int DIVW   = (NW1 > GW + pds_pkg::DEN_W) ? NW1 : GW + pds_pkg::DEN_W;
	localparam int STEP_W = $clog2(GW + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_PFD_GO, ST_PFD_WT, ST_MUL1, ST_M_GO, ST_M_WT,
		ST_MUL2, ST_G_GO, ST_G_WT, ST_NEXT, ST_DONE
	} state_t;

	state_t                      state_q;
	logic [pds_pkg::TGT_W-1:0]   tgt_q;
	logic [POST_SHIFT_COUNT-1:0] mask_q;
	logic [SCW-1:0]              s_q;
	logic [PW-1:0]               p_q;
	logic [VCO_W-1:0]            vco_q;
	logic [DIVW-1:0]             prod1_q;
	logic [GW-1:0]               prod2_q;
	logic [FBW-1:0]              m_q;

	logic                        have_q;
	logic [pds_pkg::FREQ_W-1:0]  best_err_q;
	logic [pds_pkg::FREQ_W-1:0]  best_got_q;
	logic [PW-1:0]               best_p_q;
	logic [FBW-1:0]              best_m_q;
	logic [SCW-1:0]              best_s_q;

	logic                        out_valid_q;
	logic                        found_q;
	logic [pds_pkg::PDIV_W-1:0]  pre_div_q;
	logic [pds_pkg::FDIV_W-1:0]  fb_div_q;
	logic [pds_pkg::SHIFT_W-1:0] post_shift_q;
	logic [pds_pkg::FREQ_W-1:0]  achieved_q;
	logic [pds_pkg::FREQ_W-1:0]  error_q;

	logic                        div_start;
	logic [DIVW-1:0]             div_num;
	logic [pds_pkg::DEN_W-1:0]   div_den;
	logic [STEP_W-1:0]           div_steps;
	logic                        div_done;
	logic [GW-1:0]               div_quot;

	logic [pds_pkg::DEN_W-1:0]   ref2;
	logic [DIVW-1:0]             m_lim;
	logic                        m_big;
	logic [VCO_W+PW-1:0]         mul1;
	logic [GW-1:0]               mul2;
	logic [pds_pkg::PFD_W-1:0]   pfd;
	logic                        pfd_ok;
	logic [FBW-1:0]              m_new;
	logic                        m_ok;
	logic [GW-1:0]               got_raw;
	logic [pds_pkg::FREQ_W-1:0]  got;
	logic [pds_pkg::FREQ_W-1:0]  tgt_ext;
	logic [pds_pkg::FREQ_W-1:0]  err;
	logic                        last_p;

	assign ref2    = {cfg.ref_khz, 1'b0};
	assign m_lim   = DIVW'(ref2) << FBW;
	assign m_big   = prod1_q >= m_lim;
	assign mul1    = vco_q * p_q;
	assign mul2    = m_q * ref2;
	assign pfd     = div_quot[pds_pkg::PFD_W-1:0];
	assign pfd_ok  = (pfd >= cfg.pfd_min) && (pfd <= cfg.pfd_max);
	assign m_new   = div_quot[FBW-1:0];
	assign m_ok    = (m_new >= FBW'(pds_pkg::FB_DIV_MIN)) && (m_new <= FBW'(FB_DIV_MAX));
	assign got_raw = div_quot >> s_q;
	assign got     = pds_pkg::FREQ_W'(got_raw);
	assign tgt_ext = pds_pkg::FREQ_W'(tgt_q);
	assign err     = (got > tgt_ext) ? got - tgt_ext : tgt_ext - got;
	assign last_p  = p_q == PW'(PRE_DIV_MAX);
	assign q_pop   = (state_q == ST_IDLE) && q_valid;

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		div_steps = '0;
		case (state_q)
			ST_PFD_GO: begin
				div_start = 1'b1;
				div_num   = DIVW'(cfg.ref_khz);
				div_den   = pds_pkg::DEN_W'(p_q);
				div_steps = STEP_W'(pds_pkg::REF_W);
			end
			ST_M_GO: begin
				div_start = !m_big;
				div_num   = prod1_q;
				div_den   = ref2;
				div_steps = STEP_W'(FBW);
			end
			ST_G_GO: begin
				div_start = 1'b1;
				div_num   = DIVW'(prod2_q);
				div_den   = pds_pkg::DEN_W'(p_q);
				div_steps = STEP_W'(GW);
			end
			default: begin
			end
		endcase
	end

	pds_div #(
		.NUM_W (DIVW),
		.QUO_W (GW),
		.STEP_W(STEP_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.steps (div_steps),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			have_q      <= 1'b0;
		end else begin
			// ST_DONE reloads the register itself when the old beat leaves
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						tgt_q      <= q_target;
						mask_q     <= q_mask;
						s_q        <= '0;
						have_q     <= 1'b0;
						best_err_q <= '0;
						best_got_q <= '0;
						best_p_q   <= '0;
						best_m_q   <= '0;
						best_s_q   <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (mask_q[0]) begin
						vco_q   <= VCO_W'(tgt_q) << s_q;
						p_q     <= PW'(1);
						state_q <= ST_PFD_GO;
					end else if (mask_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						mask_q <= mask_q >> 1;
						s_q    <= s_q + 1'b1;
					end
				end
				ST_PFD_GO: state_q <= ST_PFD_WT;
				ST_PFD_WT: begin
					if (div_done) begin
						state_q <= pfd_ok ? ST_MUL1 : ST_NEXT;
					end
				end
				ST_MUL1: begin
					prod1_q <= DIVW'(mul1) + DIVW'(cfg.ref_khz);
					state_q <= ST_M_GO;
				end
				ST_M_GO: state_q <= m_big ? ST_NEXT : ST_M_WT;
				ST_M_WT: begin
					if (div_done) begin
						m_q     <= m_new;
						state_q <= m_ok ? ST_MUL2 : ST_NEXT;
					end
				end
				ST_MUL2: begin
					prod2_q <= mul2;
					state_q <= ST_G_GO;
				end
				ST_G_GO: state_q <= ST_G_WT;
				ST_G_WT: begin
					if (div_done) begin
						if (!have_q || err < best_err_q) begin
							have_q     <= 1'b1;
							best_err_q <= err;
							best_got_q <= got;
							best_p_q   <= p_q;
							best_m_q   <= m_q;
							best_s_q   <= s_q;
						end
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (last_p) begin
						mask_q  <= mask_q >> 1;
						s_q     <= s_q + 1'b1;
						state_q <= ST_SCAN;
					end else begin
						p_q     <= p_q + 1'b1;
						state_q <= ST_PFD_GO;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						found_q      <= have_q;
						pre_div_q    <= pds_pkg::PDIV_W'(best_p_q);
						fb_div_q     <= pds_pkg::FDIV_W'(best_m_q);
						post_shift_q <= pds_pkg::SHIFT_W'(best_s_q);
						achieved_q   <= best_got_q;
						error_q      <= best_err_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign pre_div      = pre_div_q;
	assign fb_div       = fb_div_q;
	assign post_shift   = post_shift_q;
	assign achieved_khz = achieved_q;
	assign error_khz    = error_q;

endmodule

// ===== rtl/pll_divider_search.sv =====
// Search: per S in the VCO window, one pass over the 63 pairs (P = 1 to 63); a P that fails the ref/P
// window skips the M and achieved-frequency divisions, and S outside the window are skipped in ST_SCAN.
// The shared serial divider (one quotient bit per cycle) runs 16, 10 and 27 steps for the three divisions.
// Targets are searched one at a time; a 2-beat queue and the output register keep both sides
// moving independently, so a new target is taken while a result waits.
// Reset (arst_n low, async): queue empty, no result pending, config registers at defaults.
module pll_divider_search #(
	parameter int PRE_DIV_MAX      = pds_pkg::DEF_PRE_DIV_MAX,
	parameter int FB_DIV_MAX       = pds_pkg::DEF_FB_DIV_MAX,
	parameter int POST_SHIFT_COUNT = pds_pkg::DEF_POST_SHIFT_COUNT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// config write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pds_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pds_pkg::CFG_DATA_W-1:0]  cfg_data,
	// request channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [pds_pkg::TGT_W-1:0]       target_khz,
	// result channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            found,
	output logic [pds_pkg::PDIV_W-1:0]      pre_div,
	output logic [pds_pkg::FDIV_W-1:0]      fb_div,
	output logic [pds_pkg::SHIFT_W-1:0]     post_shift,
	output logic [pds_pkg::FREQ_W-1:0]      achieved_khz,
	output logic [pds_pkg::FREQ_W-1:0]      error_khz
);

	// VCO = target << S needs room for the largest shift
	localparam int VCO_W = pds_pkg::TGT_W + POST_SHIFT_COUNT - 1;

	pds_pkg::cfg_t               cfg_q;
	logic                        q_valid;
	logic                        q_pop;
	logic [pds_pkg::TGT_W-1:0]   q_target;
	logic [POST_SHIFT_COUNT-1:0] q_mask;

	// Config writes always land in one beat; writes past the last index drop.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ref_khz <= pds_pkg::RST_REF;
			cfg_q.vco_min <= pds_pkg::RST_VCO_MIN;
			cfg_q.vco_max <= pds_pkg::RST_VCO_MAX;
			cfg_q.pfd_min <= pds_pkg::RST_PFD_MIN;
			cfg_q.pfd_max <= pds_pkg::RST_PFD_MAX;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pds_pkg::CFG_REF:     cfg_q.ref_khz <= cfg_data[pds_pkg::REF_W-1:0];
				pds_pkg::CFG_VCO_MIN: cfg_q.vco_min <= cfg_data[pds_pkg::WIN_W-1:0];
				pds_pkg::CFG_VCO_MAX: cfg_q.vco_max <= cfg_data[pds_pkg::WIN_W-1:0];
				pds_pkg::CFG_PFD_MIN: cfg_q.pfd_min <= cfg_data[pds_pkg::PFD_W-1:0];
				pds_pkg::CFG_PFD_MAX: cfg_q.pfd_max <= cfg_data[pds_pkg::PFD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front: VCO window check for every S in parallel (and ref == 0 kills all),
	// result mask rides along with the target in the queue.
	pds_front #(
		.POST_SHIFT_COUNT(POST_SHIFT_COUNT),
		.VCO_W           (VCO_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.target_khz(target_khz),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_target  (q_target),
		.q_mask    (q_mask)
	);

	// Back: sequencer over flagged S and every P, sharing one serial divider
	// for ref/P, rounded M, and achieved frequency; first strictly best wins.
	pds_back #(
		.PRE_DIV_MAX     (PRE_DIV_MAX),
		.FB_DIV_MAX      (FB_DIV_MAX),
		.POST_SHIFT_COUNT(POST_SHIFT_COUNT),
		.VCO_W           (VCO_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_target    (q_target),
		.q_mask      (q_mask),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.pre_div     (pre_div),
		.fb_div      (fb_div),
		.post_shift  (post_shift),
		.achieved_khz(achieved_khz),
		.error_khz   (error_khz)
	);

endmodule

// ===== rtl/pds_chk.sv =====
// Port-level checker for the divider search, bound to the top level.
module pds_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic                             found,
	input logic [pds_pkg::PDIV_W-1:0]       pre_div,
	input logic [pds_pkg::FDIV_W-1:0]       fb_div,
	input logic [pds_pkg::SHIFT_W-1:0]      post_shift,
	input logic [pds_pkg::FREQ_W-1:0]       achieved_khz,
	input logic [pds_pkg::FREQ_W-1:0]       error_khz
);

	// not-found beats carry all-zero fields
	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> pre_div == '0 && fb_div == '0 && post_shift == '0
			&& achieved_khz == '0 && error_khz == '0)
		else $error("not-found result with nonzero fields");

	// a found set has a real P and M at or above the floor
	a_found_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |->
			pre_div != '0 && fb_div >= pds_pkg::FDIV_W'(pds_pkg::FB_DIV_MIN))
		else $error("found result with out-of-range divider");

	// stalled result beat holds valid, found, P, M, achieved and error
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(pre_div)
			&& $stable(fb_div) && $stable(achieved_khz) && $stable(error_khz))
		else $error("result beat changed while stalled");

endmodule

bind pll_divider_search pds_chk u_pds_chk (.*);

// ===== tb/sv/tb_pll_divider_search.sv =====
// Self-checking testbench for the PLL divider search block.
module tb_pll_divider_search;
	timeunit 1ns;
	timeprecision 1ps;

	// Register index past the list; the block must ignore the write
	localparam logic [pds_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

	typedef struct {
		logic                         found;
		logic [pds_pkg::PDIV_W-1:0]   pre_div;
		logic [pds_pkg::FDIV_W-1:0]   fb_div;
		logic [pds_pkg::SHIFT_W-1:0]  post_shift;
		logic [pds_pkg::FREQ_W-1:0]   achieved_khz;
		logic [pds_pkg::FREQ_W-1:0]   error_khz;
	} divider_set_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pds_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pds_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [pds_pkg::TGT_W-1:0] target_khz = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic found;
	logic [pds_pkg::PDIV_W-1:0] pre_div;
	logic [pds_pkg::FDIV_W-1:0] fb_div;
	logic [pds_pkg::SHIFT_W-1:0] post_shift;
	logic [pds_pkg::FREQ_W-1:0] achieved_khz;
	logic [pds_pkg::FREQ_W-1:0] error_khz;

	// Our own copy of the register file
	logic [pds_pkg::REF_W-1:0] m_ref;
	logic [pds_pkg::WIN_W-1:0] m_vco_min, m_vco_max;
	logic [pds_pkg::PFD_W-1:0] m_pfd_min, m_pfd_max;

	logic [pds_pkg::TGT_W-1:0] pending_targets[$];
	divider_set_t expected_sets[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int results_seen = 0;
	int results_found = 0;

	pll_divider_search u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Exhaustive (S, P) scan; S ascending, then P; strict improvement only.
	function automatic divider_set_t search_divider(logic [pds_pkg::TGT_W-1:0] tgt);
		divider_set_t best;
		longint unsigned vco, pfd, fb, got, err, best_err, refk;
		bit have;
		best = '{default: '0};
		have = 0;
		best_err = 0;
		refk = m_ref;
		if (refk != 0) begin
			for (int s = 0; s < pds_pkg::DEF_POST_SHIFT_COUNT; s++) begin
				vco = longint'(tgt) << s;
				if (vco < m_vco_min || vco > m_vco_max)
					continue;
				for (int p = 1; p <= pds_pkg::DEF_PRE_DIV_MAX; p++) begin
					pfd = refk / p;
					if (pfd < m_pfd_min || pfd > m_pfd_max)
						continue;
					fb = (vco * p + refk) / (2 * refk);
					if (fb < pds_pkg::FB_DIV_MIN || fb > pds_pkg::DEF_FB_DIV_MAX)
						continue;
					got = ((fb * 2 * refk) / p) >> s;
					err = (got > tgt) ? got - tgt : tgt - got;
					if (!have || err < best_err) begin
						have = 1;
						best_err = err;
						best.found = 1'b1;
						best.pre_div = p[pds_pkg::PDIV_W-1:0];
						best.fb_div = fb[pds_pkg::FDIV_W-1:0];
						best.post_shift = s[pds_pkg::SHIFT_W-1:0];
						best.achieved_khz = got[pds_pkg::FREQ_W-1:0];
						best.error_khz = err[pds_pkg::FREQ_W-1:0];
					end
				end
			end
		end
		return best;
	endfunction

	// Request driver: valid holds until accepted, gaps drawn per cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (pending_targets.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				target_khz <= pending_targets.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result-side backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: predict on accepted requests, check accepted result beats
	always @(posedge clk) begin
		divider_set_t want;
		if (arst_n && in_valid && in_ready)
			expected_sets.push_back(search_divider(target_khz));
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (found)
				results_found++;
			if (expected_sets.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result beat with nothing expected");
			end else begin
				want = expected_sets.pop_front();
				if (found !== want.found || pre_div !== want.pre_div ||
				    fb_div !== want.fb_div || post_shift !== want.post_shift ||
				    achieved_khz !== want.achieved_khz || error_khz !== want.error_khz) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("ERROR: exp f=%0d P=%0d M=%0d S=%0d got=%0d err=%0d",
							want.found, want.pre_div, want.fb_div, want.post_shift,
							want.achieved_khz, want.error_khz);
						$display("       act f=%0d P=%0d M=%0d S=%0d got=%0d err=%0d",
							found, pre_div, fb_div, post_shift, achieved_khz, error_khz);
					end
				end
			end
		end
	end

	// One config beat; the shadow copy follows only on acceptance
	task automatic write_reg(logic [pds_pkg::CFG_IDX_W-1:0] idx,
			logic [pds_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			pds_pkg::CFG_REF:     m_ref = val[pds_pkg::REF_W-1:0];
			pds_pkg::CFG_VCO_MIN: m_vco_min = val;
			pds_pkg::CFG_VCO_MAX: m_vco_max = val;
			pds_pkg::CFG_PFD_MIN: m_pfd_min = val[pds_pkg::PFD_W-1:0];
			pds_pkg::CFG_PFD_MAX: m_pfd_max = val[pds_pkg::PFD_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic set_windows(logic [pds_pkg::CFG_DATA_W-1:0] rk,
			logic [pds_pkg::CFG_DATA_W-1:0] vlo, logic [pds_pkg::CFG_DATA_W-1:0] vhi,
			logic [pds_pkg::CFG_DATA_W-1:0] plo, logic [pds_pkg::CFG_DATA_W-1:0] phi);
		write_reg(pds_pkg::CFG_REF, rk);
		write_reg(pds_pkg::CFG_VCO_MIN, vlo);
		write_reg(pds_pkg::CFG_VCO_MAX, vhi);
		write_reg(pds_pkg::CFG_PFD_MIN, plo);
		write_reg(pds_pkg::CFG_PFD_MAX, phi);
	endtask

	// Mostly targets whose VCO lands in the window for some S, rest full-range noise
	task automatic queue_random(int n);
		longint unsigned v;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 70 && m_vco_min <= m_vco_max) begin
				v = m_vco_min + ($urandom % (longint'(m_vco_max - m_vco_min) + 1));
				pending_targets.push_back(pds_pkg::TGT_W'(v >> $urandom_range(6)));
			end else begin
				pending_targets.push_back(pds_pkg::TGT_W'($urandom));
			end
		end
	endtask

	// Block until everything queued has gone through and come back
	task automatic drain();
		while (pending_targets.size() != 0 || in_valid || expected_sets.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_idling(int snd, int rcv);
		send_idle_pct = snd;
		recv_stall_pct = rcv;
	endtask

	initial begin
		m_ref = pds_pkg::RST_REF;
		m_vco_min = pds_pkg::RST_VCO_MIN;
		m_vco_max = pds_pkg::RST_VCO_MAX;
		m_pfd_min = pds_pkg::RST_PFD_MIN;
		m_pfd_max = pds_pkg::RST_PFD_MAX;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values, directed targets: field extremes, window edges, bit patterns
		set_idling(0, 0);
		pending_targets = '{24'd0, 24'd1, 24'd2599999, 24'd2600000, 24'd6600000,
			24'd6600001, 24'hFFFFFF, 24'h800000, 24'hAAAAAA, 24'h555555, 24'd3300000,
			24'd40625, 24'd51562, 24'd1000000, 24'd100000};
		drain();
		queue_random(150);
		drain();

		// Wide PFD window: many P survive per S; sender gaps
		set_idling(51, 0);
		set_windows(24'd25000, 24'd1000000, 24'd4000000, 24'd1000, 24'd25000);
		queue_random(150);
		drain();

		// Top extremes: VCO window open end to end, max reference; receiver stalls
		set_idling(0, 51);
		set_windows(24'd65535, 24'd0, 24'hFFFFFF, 24'd30000, 24'd65535);
		queue_random(20);
		drain();

		// Zero reference after masking, ignored index, inverted VCO window
		set_idling(37, 37);
		set_windows(24'hFF0000, 24'd5000000, 24'd1000000, 24'd0, 24'd0);
		write_reg(CFG_IDX_UNUSED, 24'h123456);
		queue_random(10);
		drain();

		// Reference of one: ref/P truncates to zero beyond P=1
		set_windows(24'd1, 24'd100, 24'd3000, 24'd0, 24'd65535);
		queue_random(150);
		drain();

		set_windows(24'd12000, 24'd2000000, 24'd8000000, 24'd6000, 24'd12000);
		queue_random(200);
		drain();
		repeat (50) @(posedge clk);

		$display("Checked %0d searches (%0d found a divider set) over six register settings",
			results_seen, results_found);
		$display("with sender gaps and receiver stalls; %0d mismatches", mismatches);
		if (mismatches == 0 && expected_sets.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog: well past every target taking the full (S, P) scan
	initial begin
		#2_000_000_000;
		$display("Timeout waiting for results");
		$display("Simulation FAILED");
		$finish;
	end

endmodule
